// ----- rtl/mpgi_pkg.sv -----
// Shared types, codes and tables for the MPEG-2 picture/GOP indexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mpgi_pkg;

  localparam logic [7:0] SC_SEQUENCE = 8'hB3;
  localparam logic [7:0] SC_GOP      = 8'hB8;
  localparam logic [7:0] SC_PICTURE  = 8'h00;

  localparam int REC_DEPTH = 4;
  localparam int REC_PTR_W = 2;
  localparam int REC_CNT_W = 3;

  typedef enum logic [2:0] {
    KIND_GOP_CLOSED = 3'd0,
    KIND_SEQ_INFO   = 3'd1,
    KIND_TIMECODE   = 3'd2,
    KIND_FRAME      = 3'd3,
    KIND_ILLEGAL    = 3'd4,
    KIND_OVERFLOW   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [47:0] abs_position;
    logic [31:0] rel_position;
    logic [31:0] header_bits;
  } item_t;

  typedef struct packed {
    kind_e       record_kind;
    logic        last;
    logic [31:0] gop_index;
    logic [31:0] image_index;
    logic [8:0]  frame_slot;
    logic [2:0]  picture_type;
    logic [47:0] abs_position;
    logic [31:0] rel_position;
    logic [25:0] frame_size;
    logic [3:0]  aspect_code;
    logic [15:0] frame_rate_milli;
    logic [22:0] timecode;
  } record_t;

  // One processed item: zero, one or two records
  typedef struct packed {
    logic [1:0] count;
    record_t    rec0;
    record_t    rec1;
  } push_t;

  typedef struct packed {
    logic [REC_CNT_W-1:0] count;
    logic                 space_ok;
  } fifo_stat_t;

  function automatic logic [15:0] rate_milli(input logic [3:0] code);
    logic [15:0] r;
    case (code)
      4'd1:    r = 16'd23976;
      4'd2:    r = 16'd24000;
      4'd3:    r = 16'd25000;
      4'd4:    r = 16'd29970;
      4'd5:    r = 16'd30000;
      4'd6:    r = 16'd50000;
      4'd7:    r = 16'd59940;
      4'd8:    r = 16'd60000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] round16(input logic [11:0] v);
    logic [12:0] s;
    s = {1'b0, v} + 13'd15;
    return {s[12:4], 4'b0000};
  endfunction

endpackage

// ----- rtl/mpgi_front.sv -----
// Input register stage of the indexer: holds one start-code request.
// Depends on mpgi_pkg.
`timescale 1ns / 1ps

module mpgi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mpgi_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output mpgi_pkg::item_t item_o
);
  import mpgi_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/mpgi_core.sv -----
// Record generation and GOP/picture counters of the indexer.
// Depends on mpgi_pkg.
`timescale 1ns / 1ps

module mpgi_core #(
  parameter int MAX_FRAMES_PER_GOP = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  mpgi_pkg::item_t item_i,
  output mpgi_pkg::push_t push_o
);
  import mpgi_pkg::*;

  localparam logic [8:0] MaxSlots = 9'(MAX_FRAMES_PER_GOP);

  logic        seen_q, seen_d;
  logic        awaiting_q, awaiting_d;
  logic [31:0] gop_cnt_q, gop_cnt_d;
  logic [31:0] img_cnt_q, img_cnt_d;
  logic [8:0]  pics_q, pics_d;
  logic [47:0] start_abs_q, start_abs_d;
  logic [31:0] start_rel_q, start_rel_d;

  logic        is_seq, is_gop, is_pic;
  logic        do_close, has_main;
  logic [31:0] gop_after, img_after;
  logic [2:0]  ptype;
  record_t     close_rec, main_rec;
  push_t       push;

  always_comb begin
    is_seq = (item_i.start_code == SC_SEQUENCE);
    is_gop = (item_i.start_code == SC_GOP);
    is_pic = (item_i.start_code == SC_PICTURE);
    ptype  = item_i.header_bits[21:19];

    do_close = (pics_q != 9'd0) & ~awaiting_q & (is_seq | (is_gop & seen_q));
    gop_after = do_close ? gop_cnt_q + 32'd1 : gop_cnt_q;
    img_after = do_close ? img_cnt_q + {23'd0, pics_q} : img_cnt_q;

    seen_d      = seen_q;
    awaiting_d  = awaiting_q;
    gop_cnt_d   = gop_after;
    img_cnt_d   = img_after;
    pics_d      = do_close ? 9'd0 : pics_q;
    start_abs_d = do_close ? item_i.abs_position : start_abs_q;
    start_rel_d = do_close ? item_i.rel_position : start_rel_q;

    close_rec              = '0;
    close_rec.record_kind  = KIND_GOP_CLOSED;
    close_rec.gop_index    = gop_cnt_q;
    close_rec.image_index  = img_cnt_q;
    close_rec.frame_slot   = pics_q;
    close_rec.abs_position = item_i.abs_position;
    close_rec.rel_position = item_i.rel_position;

    main_rec              = '0;
    main_rec.record_kind  = KIND_SEQ_INFO;
    main_rec.gop_index    = gop_after;
    main_rec.image_index  = img_after;
    main_rec.abs_position = item_i.abs_position;
    main_rec.rel_position = item_i.rel_position;
    has_main = 1'b0;

    if (is_seq && !awaiting_q) begin
      awaiting_d = 1'b1;
      if (!seen_q) begin
        has_main                  = 1'b1;
        seen_d                    = 1'b1;
        start_abs_d               = item_i.abs_position;
        start_rel_d               = item_i.rel_position;
        main_rec.frame_size       = {round16(item_i.header_bits[31:20]),
                                     round16(item_i.header_bits[19:8])};
        main_rec.aspect_code      = item_i.header_bits[7:4];
        main_rec.frame_rate_milli = rate_milli(item_i.header_bits[3:0]);
      end
    end else if (is_gop && seen_q) begin
      has_main             = 1'b1;
      main_rec.record_kind = KIND_TIMECODE;
      main_rec.timecode    = {item_i.header_bits[30:26], item_i.header_bits[25:20],
                              item_i.header_bits[18:13], item_i.header_bits[12:7]};
    end else if (is_pic && seen_q) begin
      has_main              = 1'b1;
      awaiting_d            = 1'b0;
      main_rec.frame_slot   = pics_q;
      main_rec.picture_type = ptype;
      if (ptype == 3'd0 || ptype > 3'd3) begin
        main_rec.record_kind = KIND_ILLEGAL;
      end else if (pics_q >= MaxSlots) begin
        main_rec.record_kind = KIND_OVERFLOW;
      end else begin
        main_rec.record_kind = KIND_FRAME;
        pics_d               = pics_q + 9'd1;
        // first picture of a GOP is indexed at the GOP start
        if (pics_q == 9'd0) begin
          main_rec.abs_position = start_abs_q;
          main_rec.rel_position = start_rel_q;
        end
      end
    end

    main_rec.last  = 1'b1;
    close_rec.last = ~has_main;

    push = '0;
    if (advance_i) begin
      if (do_close) begin
        push.rec0  = close_rec;
        push.rec1  = main_rec;
        push.count = has_main ? 2'd2 : 2'd1;
      end else if (has_main) begin
        push.rec0  = main_rec;
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      awaiting_q  <= 1'b0;
      gop_cnt_q   <= '0;
      img_cnt_q   <= '0;
      pics_q      <= '0;
      start_abs_q <= '0;
      start_rel_q <= '0;
    end else if (advance_i) begin
      seen_q      <= seen_d;
      awaiting_q  <= awaiting_d;
      gop_cnt_q   <= gop_cnt_d;
      img_cnt_q   <= img_cnt_d;
      pics_q      <= pics_d;
      start_abs_q <= start_abs_d;
      start_rel_q <= start_rel_d;
    end
  end

  assign push_o = push;

endmodule

// ----- rtl/mpgi_rec_fifo.sv -----
// Output record queue: takes up to two records a cycle, hands out one while out_stall_i is low.
// Depends on mpgi_pkg.
`timescale 1ns / 1ps

module mpgi_rec_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpgi_pkg::push_t      push_i,
  output mpgi_pkg::fifo_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mpgi_pkg::record_t    rec_o
);
  import mpgi_pkg::*;

  localparam logic [REC_CNT_W-1:0] SpaceLimit = REC_CNT_W'(REC_DEPTH - 2);

  record_t              mem_q [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [REC_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [REC_CNT_W-1:0] count_q, count_d;
  logic                 pop;

  assign pop = (count_q != '0) & ~out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + REC_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + REC_PTR_W'(pop);
    count_d  = count_q + REC_CNT_W'(push_i.count) - REC_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + REC_PTR_W'(1)] <= push_i.rec1;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign rec_o          = mem_q[rd_ptr_q];
  assign stat_o.count   = count_q;
  assign stat_o.space_ok = (count_q <= SpaceLimit);

endmodule

// ----- rtl/mpeg2_picture_gop_indexer.sv -----
// MPEG-2 picture/GOP indexer top level: input register, record logic, output queue.
// Records of a request are offered after the input register and the record queue.
// Throughput: one request per cycle while each yields at most one record and the
// output is not stalled; a GOP header that closes a GOP yields two records, which
// leave one at a time. Rate is set by the single output port of the record queue.
// Reset: rst_ni asynchronously clears counters, flags and the queue.
`timescale 1ns / 1ps

module mpeg2_picture_gop_indexer #(
  parameter int MAX_FRAMES_PER_GOP = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  start_code_i,
  input  logic [47:0] abs_position_i,
  input  logic [31:0] rel_position_i,
  input  logic [31:0] header_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic        last_o,
  output logic [31:0] gop_index_o,
  output logic [31:0] image_index_o,
  output logic [8:0]  frame_slot_o,
  output logic [2:0]  picture_type_o,
  output logic [47:0] out_abs_position_o,
  output logic [31:0] out_rel_position_o,
  output logic [25:0] frame_size_o,
  output logic [3:0]  aspect_code_o,
  output logic [15:0] frame_rate_milli_o,
  output logic [22:0] timecode_o
);
  import mpgi_pkg::*;

  item_t      in_item, reg_item;
  logic       reg_valid, advance;
  push_t      push;
  fifo_stat_t stat;
  record_t    rec;

  assign in_item.start_code   = start_code_i;
  assign in_item.abs_position = abs_position_i;
  assign in_item.rel_position = rel_position_i;
  assign in_item.header_bits  = header_bits_i;

  // process the held request only when the queue can take two records
  assign advance = reg_valid & stat.space_ok;

  mpgi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (reg_valid),
    .item_o     (reg_item)
  );

  mpgi_core #(
    .MAX_FRAMES_PER_GOP (MAX_FRAMES_PER_GOP)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (reg_item),
    .push_o    (push)
  );

  mpgi_rec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec)
  );

  assign record_kind_o      = rec.record_kind;
  assign last_o             = rec.last;
  assign gop_index_o        = rec.gop_index;
  assign image_index_o      = rec.image_index;
  assign frame_slot_o       = rec.frame_slot;
  assign picture_type_o     = rec.picture_type;
  assign out_abs_position_o = rec.abs_position;
  assign out_rel_position_o = rec.rel_position;
  assign frame_size_o       = rec.frame_size;
  assign aspect_code_o      = rec.aspect_code;
  assign frame_rate_milli_o = rec.frame_rate_milli;
  assign timecode_o         = rec.timecode;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= REC_CNT_W'(REC_DEPTH))
    else $error("record queue overfilled");

  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> (reg_valid && stat.space_ok))
    else $error("records pushed without a held request");

  a_frame_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o == KIND_FRAME) |->
      (frame_slot_o < 9'(MAX_FRAMES_PER_GOP)))
    else $error("frame slot beyond GOP limit");

  a_size_only_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o != KIND_SEQ_INFO) |-> (frame_size_o == 26'd0))
    else $error("frame size outside sequence record");

endmodule
